/* sv/bmp24_pkg.sv */
// bmp24_pkg: shared types and constants of the 24-bit bitmap byte parser
// no dependencies; imported by bmp24_hdr, bmp_24bit_byte_stream_parser_unit and its test bench
`timescale 1ns / 1ps

package bmp24_pkg;

    // result kinds, carried on m_tuser
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_SIGNATURE   = 3'd0;
    localparam logic [2:0] ERR_HDR_SIZE    = 3'd1;
    localparam logic [2:0] ERR_PLANES      = 3'd2;
    localparam logic [2:0] ERR_DEPTH       = 3'd3;
    localparam logic [2:0] ERR_COMPRESSION = 3'd4;
    localparam logic [2:0] ERR_IMPORTANT   = 3'd5;
    localparam logic [2:0] ERR_TOO_LARGE   = 3'd6;

    // byte positions at which a header field is complete
    localparam logic [7:0] POS_SIG         = 8'd1;
    localparam logic [7:0] POS_HDR_SIZE    = 8'd17;
    localparam logic [7:0] POS_WIDTH       = 8'd21;
    localparam logic [7:0] POS_HEIGHT      = 8'd25;
    localparam logic [7:0] POS_PLANES      = 8'd27;
    localparam logic [7:0] POS_DEPTH       = 8'd29;
    localparam logic [7:0] POS_COMPRESSION = 8'd33;
    localparam logic [7:0] POS_IMPORTANT   = 8'd53;
    localparam logic [7:0] HDR_BASE        = 8'd13;
    localparam logic [7:0] COUNT_MAX       = 8'd255;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    localparam logic [31:0] HLEN_40  = 32'd40;
    localparam logic [31:0] HLEN_52  = 32'd52;
    localparam logic [31:0] HLEN_56  = 32'd56;
    localparam logic [31:0] HLEN_108 = 32'd108;
    localparam logic [31:0] HLEN_124 = 32'd124;

    localparam logic [15:0] PLANES_ONE = 16'd1;
    localparam logic [15:0] BPP_24     = 16'd24;

    typedef enum logic [2:0] {
        PH_HDR  = 3'b001,
        PH_PIX  = 3'b010,
        PH_IDLE = 3'b100
    } phase_t;

    typedef struct packed {
        logic       err;
        logic [2:0] code;
        logic       done;
    } hdr_evt_t;

endpackage

/* sv/bmp24_hdr.sv */
// bmp24_hdr: header field capture and checks, one byte per accepted item
// depends on bmp24_pkg
`timescale 1ns / 1ps

module bmp24_hdr
    import bmp24_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    localparam int DIM_W = $clog2(MAX_DIM + 2)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             restart,
    input  logic             step,
    input  logic [7:0]       data_byte,
    output hdr_evt_t         evt,
    output logic [DIM_W-1:0] img_width,
    output logic [DIM_W-1:0] img_height
);

    logic [7:0]       cnt_reg, cnt_next, cnt_base;
    logic [31:0]      word_reg, word_next, word_base, word_new;
    logic [6:0]       hlen_reg, hlen_next, hlen_base;
    logic [DIM_W-1:0] width_reg, width_next, width_base;
    logic [DIM_W-1:0] height_reg, height_next, height_base;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [31:0] v);
        return (v > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM + 1) : DIM_W'(v);
    endfunction

    always_comb begin
        cnt_base    = restart ? '0 : cnt_reg;
        word_base   = restart ? '0 : word_reg;
        hlen_base   = restart ? '0 : hlen_reg;
        width_base  = restart ? '0 : width_reg;
        height_base = restart ? '0 : height_reg;
        word_new    = {data_byte, word_base[31:8]};

        cnt_next    = cnt_base;
        word_next   = word_base;
        hlen_next   = hlen_base;
        width_next  = width_base;
        height_next = height_base;
        evt         = '0;

        if (step) begin
            word_next = word_new;
            cnt_next  = (cnt_base < COUNT_MAX) ? cnt_base + 8'd1 : cnt_base;
            unique case (cnt_base)
                POS_SIG: begin
                    if (word_new[23:16] != SIG_B || word_new[31:24] != SIG_M) begin
                        evt.err  = 1'b1;
                        evt.code = ERR_SIGNATURE;
                    end
                end
                POS_HDR_SIZE: begin
                    if (word_new == HLEN_40 || word_new == HLEN_52 || word_new == HLEN_56
                        || word_new == HLEN_108 || word_new == HLEN_124) begin
                        hlen_next = word_new[6:0];
                    end else begin
                        evt.err  = 1'b1;
                        evt.code = ERR_HDR_SIZE;
                    end
                end
                POS_WIDTH: begin
                    width_next = clamp_dim(word_new);
                end
                POS_HEIGHT: begin
                    height_next = clamp_dim(word_new);
                end
                POS_PLANES: begin
                    if (word_new[31:16] != PLANES_ONE) begin
                        evt.err  = 1'b1;
                        evt.code = ERR_PLANES;
                    end
                end
                POS_DEPTH: begin
                    if (word_new[31:16] != BPP_24) begin
                        evt.err  = 1'b1;
                        evt.code = ERR_DEPTH;
                    end
                end
                POS_COMPRESSION: begin
                    if (word_new != '0) begin
                        evt.err  = 1'b1;
                        evt.code = ERR_COMPRESSION;
                    end
                end
                POS_IMPORTANT: begin
                    priority if (word_new != '0) begin
                        evt.err  = 1'b1;
                        evt.code = ERR_IMPORTANT;
                    end else if (width_base > DIM_W'(MAX_DIM)
                                 || height_base > DIM_W'(MAX_DIM)) begin
                        evt.err  = 1'b1;
                        evt.code = ERR_TOO_LARGE;
                    end else if (hlen_base == HLEN_40[6:0]) begin
                        evt.done = 1'b1;
                    end
                end
                default: begin
                    // extended header ends here
                    if (cnt_base > POS_IMPORTANT && cnt_base == HDR_BASE + 8'(hlen_base)) begin
                        evt.done = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            word_reg   <= '0;
            hlen_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end else begin
            cnt_reg    <= cnt_next;
            word_reg   <= word_next;
            hlen_reg   <= hlen_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign img_width  = width_base;
    assign img_height = height_base;

endmodule

/* sv/bmp_24bit_byte_stream_parser_unit.sv */
// bmp_24bit_byte_stream_parser_unit: top level of the 24-bit bitmap byte parser
// depends on bmp24_pkg and bmp24_hdr
//
// The s_ channel takes one byte of a bitmap file per item on s_tdata; s_tuser
// high marks byte 0 of a new file and restarts the parse. The m_ channel gives
// results: m_tuser is the kind (pixel, header accepted, error), m_tdata holds
// the pixel components, its top-down row and column, the image size with a
// header result and the error code with an error result. m_tlast flags the
// final pixel of the image.
// Every byte goes through one stage of logic into the result register, so a
// result is offered in the cycle after the byte that completes it, and a
// byte can be accepted in every cycle: one byte per cycle sustained while
// the receiver takes results. Bytes that give no result (header fields,
// the first two components of a pixel, row padding) leave nothing behind.
// If the receiver stalls, the held result stays put and s_tready drops
// until it is taken.
// Reset acts like a file start: the next byte is taken as byte 0. After an
// error or the last pixel, bytes are dropped until the next file start.
`timescale 1ns / 1ps

module bmp_24bit_byte_stream_parser_unit
    import bmp24_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    localparam int DIM_W   = $clog2(MAX_DIM + 2),
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int PAY_W   = 24 + 2 * IDX_W + 2 * DIM_W + 3,
    localparam int TDATA_W = ((PAY_W + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tuser,   // file_start
    output logic               m_tvalid,
    input  logic               m_tready,
    // red, green, blue, row_index, column_index, image_width, image_height,
    // error_code, zero fill
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast    // last_pixel
);

    logic             s_accept, restart, hdr_step;
    hdr_evt_t         evt;
    logic [DIM_W-1:0] img_width, img_height;

    phase_t           phase_reg, phase_next, phase_base;
    logic [IDX_W-1:0] row_reg, row_next, row_base;
    logic [IDX_W-1:0] col_reg, col_next, col_base;
    logic [1:0]       comp_reg, comp_next, comp_base;
    logic [1:0]       pad_reg, pad_next, pad_base;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;

    logic             res_valid, res_last, last_px;
    logic [1:0]       res_kind;
    logic [7:0]       res_red, res_green, res_blue;
    logic [IDX_W-1:0] res_row, res_col;
    logic [DIM_W-1:0] res_width, res_height;
    logic [2:0]       res_err;

    logic             m_valid_reg;
    logic [1:0]       m_kind_reg;
    logic             m_last_reg;
    logic [PAY_W-1:0] m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign restart  = s_accept && s_tuser;

    always_comb begin
        phase_base = restart ? PH_HDR : phase_reg;
        row_base   = restart ? '0 : row_reg;
        col_base   = restart ? '0 : col_reg;
        comp_base  = restart ? '0 : comp_reg;
        pad_base   = restart ? '0 : pad_reg;
        hdr_step   = s_accept && (phase_base == PH_HDR);
    end

    bmp24_hdr #(
        .MAX_DIM (MAX_DIM)
    ) u_hdr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .step       (hdr_step),
        .data_byte  (s_tdata),
        .evt        (evt),
        .img_width  (img_width),
        .img_height (img_height)
    );

    always_comb begin
        phase_next = phase_base;
        row_next   = row_base;
        col_next   = col_base;
        comp_next  = comp_base;
        pad_next   = pad_base;
        blue_next  = blue_reg;
        green_next = green_reg;

        res_valid  = 1'b0;
        res_kind   = KIND_PIXEL;
        res_last   = 1'b0;
        res_red    = '0;
        res_green  = '0;
        res_blue   = '0;
        res_row    = '0;
        res_col    = '0;
        res_width  = '0;
        res_height = '0;
        res_err    = '0;
        last_px    = 1'b0;

        if (hdr_step) begin
            if (evt.err) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res_kind   = KIND_ERROR;
                res_err    = evt.code;
            end else if (evt.done) begin
                row_next   = '0;
                col_next   = '0;
                comp_next  = '0;
                pad_next   = '0;
                phase_next = (img_width == '0 || img_height == '0) ? PH_IDLE : PH_PIX;
                res_valid  = 1'b1;
                res_kind   = KIND_HEADER;
                res_width  = img_width;
                res_height = img_height;
            end
        end else if (s_accept && phase_base == PH_PIX) begin
            priority if (pad_base != '0) begin
                pad_next = pad_base - 2'd1;
            end else if (comp_base == 2'd0) begin
                blue_next = s_tdata;
                comp_next = 2'd1;
            end else if (comp_base == 2'd1) begin
                green_next = s_tdata;
                comp_next  = 2'd2;
            end else begin
                comp_next = 2'd0;
                last_px   = (DIM_W'(row_base) + DIM_W'(1) >= img_height)
                            && (DIM_W'(col_base) + DIM_W'(1) >= img_width);
                res_valid = 1'b1;
                res_kind  = KIND_PIXEL;
                res_last  = last_px;
                res_red   = s_tdata;
                res_green = green_reg;
                res_blue  = blue_reg;
                res_row   = IDX_W'(img_height - DIM_W'(1) - DIM_W'(row_base));
                res_col   = col_base;
                if (DIM_W'(col_base) + DIM_W'(1) < img_width) begin
                    col_next = col_base + IDX_W'(1);
                end else begin
                    col_next = '0;
                    row_next = row_base + IDX_W'(1);
                    if (last_px) begin
                        phase_next = PH_IDLE;
                    end else begin
                        pad_next = img_width[1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            row_reg   <= '0;
            col_reg   <= '0;
            comp_reg  <= '0;
            pad_reg   <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            comp_reg  <= comp_next;
            pad_reg   <= pad_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            m_kind_reg <= res_kind;
            m_last_reg <= res_last;
            m_data_reg <= {res_err, res_height, res_width, res_col, res_row,
                           res_blue, res_green, res_red};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_PIXEL)
        else $error("last flag on a non-pixel result");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without an accepted item");

    a_comp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        comp_reg != 2'd3)
        else $error("component count out of range");

    a_col_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIX && !restart |-> DIM_W'(col_reg) < img_width)
        else $error("column beyond image width");

endmodule

/* dv/bmp_24bit_byte_stream_parser_unit_test.sv */
// bmp_24bit_byte_stream_parser_unit_test: self-checking bench for the 24-bit bitmap byte parser
// depends on bmp24_pkg and bmp_24bit_byte_stream_parser_unit; byte-level parser model inside
// directed bitmap files from a table, then random well-formed and broken files with random idling
`timescale 1ns / 1ps

module bmp_24bit_byte_stream_parser_unit_test;
    import bmp24_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int TDATA_W     = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES = 250;
    localparam int MAX_LAID_AREA = 64;
    localparam logic [15:0] SIG_OK = {SIG_M, SIG_B};
    localparam logic [31:0] HDR_SIZES [5] = '{HLEN_40, HLEN_52, HLEN_56, HLEN_108, HLEN_124};

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] col;
        logic [12:0] width;
        logic [12:0] height;
        logic [2:0]  code;
        logic        last;
    } parser_result_t;

    typedef struct packed {
        logic [7:0]     data;
        logic           start;
        logic           typed;
        parser_result_t want;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] sig;
        logic [31:0] hlen;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] compr;
        logic [31:0] imp;
        int          cut;
        logic        no_start;
        logic [1:0]  kind;
        logic [2:0]  code;
    } bmp_case_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'd0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    byte_item_t     byte_q [$];
    byte_item_t     cur_item;
    parser_result_t expected_q [$];
    logic [7:0]     file_bytes [$];
    int             mismatch_count = 0;
    int             results_seen   = 0;
    int             cycle_no       = 0;
    int             hold_left      = 0;
    bit             hold_done      = 1'b0;
    logic           quiet;

    // parser state
    phase_t      phase;
    logic [7:0]  byte_pos;
    logic [31:0] shift_word;
    logic [6:0]  hdr_len;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [11:0] row_cnt;
    logic [11:0] col_cnt;
    logic [1:0]  comp_cnt;
    logic [1:0]  pad_left;
    logic [7:0]  held_b;
    logic [7:0]  held_g;

    // sig, hlen, width, height, planes, bpp, compression, important, cut, no start, kind, code
    bmp_case_t directed_files [0:22] = '{
        '{SIG_OK, 40, 1, 1, PLANES_ONE, BPP_24, 0, 0, 0, 1'b1, KIND_HEADER, ERR_SIGNATURE},
        '{16'h4E42, 40, 1, 1, PLANES_ONE, BPP_24, 0, 0, 2, 1'b0, KIND_ERROR, ERR_SIGNATURE},
        '{16'h0000, 40, 1, 1, PLANES_ONE, BPP_24, 0, 0, 2, 1'b0, KIND_ERROR, ERR_SIGNATURE},
        '{SIG_OK, 41, 1, 1, PLANES_ONE, BPP_24, 0, 0, 18, 1'b0, KIND_ERROR, ERR_HDR_SIZE},
        '{SIG_OK, 32'hFFFFFFFF, 1, 1, PLANES_ONE, BPP_24, 0, 0, 18, 1'b0, KIND_ERROR,
          ERR_HDR_SIZE},
        '{SIG_OK, 40, 1, 1, 16'd0, BPP_24, 0, 0, 28, 1'b0, KIND_ERROR, ERR_PLANES},
        '{SIG_OK, 40, 1, 1, 16'hFFFF, 16'd0, 0, 0, 28, 1'b0, KIND_ERROR, ERR_PLANES},
        '{SIG_OK, 40, 1, 1, PLANES_ONE, 16'd32, 0, 0, 30, 1'b0, KIND_ERROR, ERR_DEPTH},
        '{SIG_OK, 40, 1, 1, PLANES_ONE, BPP_24, 1, 0, 34, 1'b0, KIND_ERROR, ERR_COMPRESSION},
        '{SIG_OK, 40, 1, 1, PLANES_ONE, BPP_24, 32'hFFFFFFFF, 1, 34, 1'b0, KIND_ERROR,
          ERR_COMPRESSION},
        '{SIG_OK, 40, 1, 1, PLANES_ONE, BPP_24, 0, 32'hFFFFFFFF, 54, 1'b0, KIND_ERROR,
          ERR_IMPORTANT},
        '{SIG_OK, 40, 4097, 1, PLANES_ONE, BPP_24, 0, 0, 54, 1'b0, KIND_ERROR, ERR_TOO_LARGE},
        '{SIG_OK, 40, 2, 32'hFFFFFFFF, PLANES_ONE, BPP_24, 0, 0, 54, 1'b0, KIND_ERROR,
          ERR_TOO_LARGE},
        '{SIG_OK, 52, 3, 2, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 56, 2, 3, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 108, 5, 1, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 124, 1, 4, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 40, 0, 5, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 40, 7, 0, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 40, 3, 2, PLANES_ONE, BPP_24, 0, 0, 60, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 40, 4, 3, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 40, 4096, 1, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE},
        '{SIG_OK, 40, 1, 4096, PLANES_ONE, BPP_24, 0, 0, 0, 1'b0, KIND_HEADER, ERR_SIGNATURE}
    };

    bmp_24bit_byte_stream_parser_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic clear_parser();
        phase      = PH_HDR;
        byte_pos   = '0;
        shift_word = '0;
        hdr_len    = '0;
        img_w      = '0;
        img_h      = '0;
        row_cnt    = '0;
        col_cnt    = '0;
        comp_cnt   = '0;
        pad_left   = '0;
        held_b     = '0;
        held_g     = '0;
    endtask

    task automatic flag_error(input logic [2:0] code, output bit hit, output parser_result_t r);
        phase  = PH_IDLE;
        r      = '0;
        r.kind = KIND_ERROR;
        r.code = code;
        hit    = 1'b1;
    endtask

    task automatic accept_header(output bit hit, output parser_result_t r);
        row_cnt  = '0;
        col_cnt  = '0;
        comp_cnt = '0;
        pad_left = '0;
        phase    = (img_w == 0 || img_h == 0) ? PH_IDLE : PH_PIX;
        r        = '0;
        r.kind   = KIND_HEADER;
        r.width  = img_w;
        r.height = img_h;
        hit      = 1'b1;
    endtask

    task automatic step_parser(input logic [7:0] b, input logic st, output bit hit,
                               output parser_result_t r);
        logic [7:0]  idx;
        logic [31:0] w;
        logic        last_px;
        hit = 1'b0;
        r   = '0;
        if (st)
            clear_parser();
        if (phase == PH_HDR) begin
            idx        = byte_pos;
            shift_word = {b, shift_word[31:8]};
            w          = shift_word;
            if (byte_pos != COUNT_MAX)
                byte_pos = byte_pos + 8'd1;
            case (idx)
                POS_SIG: begin
                    if (w[23:16] != SIG_B || w[31:24] != SIG_M)
                        flag_error(ERR_SIGNATURE, hit, r);
                end
                POS_HDR_SIZE: begin
                    if (w == HLEN_40 || w == HLEN_52 || w == HLEN_56 || w == HLEN_108 ||
                        w == HLEN_124)
                        hdr_len = w[6:0];
                    else
                        flag_error(ERR_HDR_SIZE, hit, r);
                end
                POS_WIDTH:  img_w = (w > 32'(MAX_DIM)) ? 13'(MAX_DIM + 1) : w[12:0];
                POS_HEIGHT: img_h = (w > 32'(MAX_DIM)) ? 13'(MAX_DIM + 1) : w[12:0];
                POS_PLANES: begin
                    if (w[31:16] != PLANES_ONE)
                        flag_error(ERR_PLANES, hit, r);
                end
                POS_DEPTH: begin
                    if (w[31:16] != BPP_24)
                        flag_error(ERR_DEPTH, hit, r);
                end
                POS_COMPRESSION: begin
                    if (w != 0)
                        flag_error(ERR_COMPRESSION, hit, r);
                end
                POS_IMPORTANT: begin
                    if (w != 0)
                        flag_error(ERR_IMPORTANT, hit, r);
                    else if (img_w > MAX_DIM || img_h > MAX_DIM)
                        flag_error(ERR_TOO_LARGE, hit, r);
                    else if (hdr_len == HLEN_40[6:0])
                        accept_header(hit, r);
                end
                default: begin
                    if (idx > POS_IMPORTANT && idx == HDR_BASE + {1'b0, hdr_len})
                        accept_header(hit, r);
                end
            endcase
        end else if (phase == PH_PIX) begin
            if (pad_left != 0) begin
                pad_left = pad_left - 2'd1;
            end else if (comp_cnt == 0) begin
                held_b   = b;
                comp_cnt = 2'd1;
            end else if (comp_cnt == 1) begin
                held_g   = b;
                comp_cnt = 2'd2;
            end else begin
                comp_cnt = 2'd0;
                last_px  = ({1'b0, row_cnt} + 13'd1 >= img_h) &&
                           ({1'b0, col_cnt} + 13'd1 >= img_w);
                hit      = 1'b1;
                r.kind   = KIND_PIXEL;
                r.red    = b;
                r.green  = held_g;
                r.blue   = held_b;
                r.row    = 12'(img_h - 13'd1 - {1'b0, row_cnt});
                r.col    = col_cnt;
                r.last   = last_px;
                if ({1'b0, col_cnt} + 13'd1 < img_w) begin
                    col_cnt = col_cnt + 12'd1;
                end else begin
                    col_cnt = '0;
                    row_cnt = row_cnt + 12'd1;
                    if (last_px)
                        phase = PH_IDLE;
                    else
                        pad_left = img_w[1:0];
                end
            end
        end
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            file_bytes.push_back(v[8*k +: 8]);
    endtask

    task automatic push_item(input logic [7:0] data, input logic start);
        byte_item_t it;
        it       = '0;
        it.data  = data;
        it.start = start;
        byte_q.push_back(it);
    endtask

    // lays out one bitmap file; with typed set, the byte that completes the first
    // result carries that result from the table
    task automatic queue_file(input bmp_case_t c, input bit typed);
        int             hlen_eff;
        int             pos;
        int             total;
        logic [63:0]    area;
        parser_result_t want;
        byte_item_t     it;
        file_bytes.delete();
        hlen_eff = (c.hlen == HLEN_52 || c.hlen == HLEN_56 || c.hlen == HLEN_108 ||
                    c.hlen == HLEN_124) ? int'(c.hlen) : 40;
        push_le(32'(c.sig), 2);
        push_le($urandom, 4);
        push_le($urandom, 4);
        push_le($urandom, 4);
        push_le(c.hlen, 4);
        push_le(c.width, 4);
        push_le(c.height, 4);
        push_le(32'(c.planes), 2);
        push_le(32'(c.bpp), 2);
        push_le(c.compr, 4);
        repeat (4) push_le($urandom, 4);
        push_le(c.imp, 4);
        repeat (hlen_eff - 40) push_le($urandom, 1);
        area = 64'(c.width) * 64'(c.height);
        // empty or large images get a few noise bytes in place of their pixel rows
        if (area != 0 && area <= MAX_LAID_AREA) begin
            repeat (c.height)
                repeat (3 * c.width + (c.width % 4)) push_le($urandom, 1);
        end else begin
            repeat ($urandom_range(12)) push_le($urandom, 1);
        end
        if (c.cut == 0)
            repeat ($urandom_range(3)) push_le($urandom, 1);
        total = (c.cut != 0 && c.cut < file_bytes.size()) ? c.cut : file_bytes.size();
        want  = '0;
        want.kind = c.kind;
        if (c.kind == KIND_HEADER) begin
            want.width  = c.width[12:0];
            want.height = c.height[12:0];
            pos = HDR_BASE + hlen_eff;
        end else begin
            want.code = c.code;
            case (c.code)
                ERR_SIGNATURE:   pos = POS_SIG;
                ERR_HDR_SIZE:    pos = POS_HDR_SIZE;
                ERR_PLANES:      pos = POS_PLANES;
                ERR_DEPTH:       pos = POS_DEPTH;
                ERR_COMPRESSION: pos = POS_COMPRESSION;
                default:         pos = POS_IMPORTANT;
            endcase
        end
        for (int i = 0; i < total; i++) begin
            it.data  = file_bytes[i];
            it.start = (i == 0) && !c.no_start;
            it.typed = typed && (i == pos);
            it.want  = want;
            byte_q.push_back(it);
        end
    endtask

    task automatic check_field(input string fname, input logic [12:0] want,
                               input logic [12:0] seen);
        if (seen !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, seen);
        end
    endtask

    always @(posedge aclk)
        cycle_no <= cycle_no + 1;

    assign quiet = cycle_no >= 600 && cycle_no < 1100;

    // byte source
    always @(posedge aclk) begin
        byte_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_q.size() != 0 && (quiet || $urandom_range(99) >= 22)) begin
                nxt = byte_q.pop_front();
                cur_item <= nxt;
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.start;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && results_seen >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= quiet || $urandom_range(99) >= 22;
        end
    end

    always @(posedge aclk) begin
        parser_result_t seen;
        parser_result_t want;
        parser_result_t pred;
        bit             hit;
        if (!aresetn) begin
            clear_parser();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                seen.kind   = m_tuser;
                seen.red    = m_tdata[7:0];
                seen.green  = m_tdata[15:8];
                seen.blue   = m_tdata[23:16];
                seen.row    = m_tdata[35:24];
                seen.col    = m_tdata[47:36];
                seen.width  = m_tdata[60:48];
                seen.height = m_tdata[73:61];
                seen.code   = m_tdata[76:74];
                seen.last   = m_tlast;
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none, got kind %0d tdata %0h", $time,
                             m_tuser, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", 13'(want.kind), 13'(seen.kind));
                    check_field("red", 13'(want.red), 13'(seen.red));
                    check_field("green", 13'(want.green), 13'(seen.green));
                    check_field("blue", 13'(want.blue), 13'(seen.blue));
                    check_field("row_index", 13'(want.row), 13'(seen.row));
                    check_field("column_index", 13'(want.col), 13'(seen.col));
                    check_field("image_width", want.width, seen.width);
                    check_field("image_height", want.height, seen.height);
                    check_field("error_code", 13'(want.code), 13'(seen.code));
                    check_field("last_pixel", 13'(want.last), 13'(seen.last));
                end
            end
            if (s_tvalid && s_tready) begin
                step_parser(cur_item.data, cur_item.start, hit, pred);
                if (cur_item.typed)
                    expected_q.push_back(cur_item.want);
                else if (hit)
                    expected_q.push_back(pred);
            end
        end
    end

    initial begin
        bmp_case_t c;
        int        directed_count;
        int        n;
        foreach (directed_files[k])
            queue_file(directed_files[k], 1'b1);
        directed_count = byte_q.size();

        // random files: mostly well formed, some broken, some noise
        while (byte_q.size() - directed_count < RANDOM_BYTES) begin
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, 24);
                repeat (n) push_item(8'($urandom_range(255)), $urandom_range(7) == 0);
            end else begin
                c          = '0;
                c.sig      = SIG_OK;
                c.hlen     = $urandom_range(1) ? HLEN_40 : HDR_SIZES[$urandom_range(4)];
                c.width    = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                c.height   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
                c.planes   = PLANES_ONE;
                c.bpp      = BPP_24;
                c.no_start = $urandom_range(19) == 0;
                if ($urandom_range(9) < 3) begin
                    case ($urandom_range(7))
                        0: c.sig    = 16'($urandom);
                        1: c.hlen   = $urandom_range(1) ? $urandom_range(130) : $urandom;
                        2: c.width  = $urandom_range(1) ? $urandom : $urandom_range(4090, 4100);
                        3: c.height = $urandom_range(1) ? $urandom : $urandom_range(4090, 4100);
                        4: c.planes = 16'($urandom);
                        5: c.bpp    = 16'($urandom);
                        6: c.compr  = $urandom_range(1) ? $urandom_range(3) : $urandom;
                        default: c.imp = $urandom_range(1) ? $urandom_range(3) : $urandom;
                    endcase
                end
                if ($urandom_range(99) < 15)
                    c.cut = $urandom_range(1, 150);
                queue_file(c, 1'b0);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        while (byte_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/bmp24_pkg.sv
sv/bmp24_hdr.sv
sv/bmp_24bit_byte_stream_parser_unit.sv
dv/bmp_24bit_byte_stream_parser_unit_test.sv
